// ===== rtl/core/ovm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ovm_pkg
// shared constants and types for the ordered verdict matcher
// ----------------------------------------------------------------------------
package ovm_pkg;
    localparam int ORDER_DEPTH_DEF   = 16;
    localparam int VERDICT_DEPTH_DEF = 16;
    localparam int STAMP_W = 63;
    localparam int ID_W    = 31;

    localparam logic [1:0] OP_PUT_STAMP   = 2'd0;
    localparam logic [1:0] OP_PUT_VERDICT = 2'd1;
    localparam logic [1:0] OP_POLL        = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_PASS     = 3'd2;
    localparam logic [2:0] ST_BLOCK    = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    flow_id;
        logic               block_bit;
    } t_cmd;
endpackage
`default_nettype wire

// ===== rtl/core/ovm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ovm_front
// two-entry command queue toward the store engine
// ----------------------------------------------------------------------------
module ovm_front import ovm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire t_cmd        i_cmd,
    output logic             o_valid,
    output t_cmd             o_cmd,
    input  wire logic        i_take
);
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];

    // queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= ~r_wr;
            end
            if (i_take && o_valid) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push && !o_full} - {1'b0, i_take && o_valid};
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_q[r_wr] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/ovm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ovm_back
// store engine: sorted stamp store, verdict store, single result register
// ----------------------------------------------------------------------------
module ovm_back import ovm_pkg::*; #(
    parameter int ORDER_DEPTH   = ORDER_DEPTH_DEF,
    parameter int VERDICT_DEPTH = VERDICT_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_cmd  i_cmd,
    output logic       o_take,
    output logic       o_empty,
    output logic [2:0] o_status,
    input  wire logic  i_pop
);
    localparam int OCW = $clog2(ORDER_DEPTH + 1);
    localparam int VCW = $clog2(VERDICT_DEPTH + 1);

    logic [STAMP_W-1:0] r_stamp [ORDER_DEPTH];
    logic [ID_W:0]      r_vent  [VERDICT_DEPTH];
    logic [OCW-1:0]     r_ocnt;
    logic [VCW-1:0]     r_vcnt;
    logic               r_res_v;
    logic [2:0]         r_res;

    logic [ORDER_DEPTH-1:0]   le_vec;
    logic [VERDICT_DEPTH-1:0] hit_vec, first_vec, before_vec;
    logic                     hit_any, oful, vful, match;
    logic [2:0]               n_res;

    // engine takes a transaction when the result slot is free or being popped
    assign o_take   = i_valid && (!r_res_v || i_pop);
    assign o_empty  = !r_res_v;
    assign o_status = r_res;
    assign oful     = (r_ocnt == OCW'(ORDER_DEPTH));
    assign vful     = (r_vcnt == VCW'(VERDICT_DEPTH));

    // parallel compares over the stores
    always_comb begin
        for (int k = 0; k < ORDER_DEPTH; k++) begin
            le_vec[k] = (OCW'(k) < r_ocnt) && (r_stamp[k] <= i_cmd.stamp);
        end
        for (int k = 0; k < VERDICT_DEPTH; k++) begin
            hit_vec[k] = (VCW'(k) < r_vcnt) && (r_vent[k][ID_W-1:0] == i_cmd.flow_id);
        end
        // prefix mask: entries after the first hit
        before_vec = '0;
        for (int k = 1; k < VERDICT_DEPTH; k++) begin
            before_vec[k] = before_vec[k-1] | hit_vec[k-1];
        end
        first_vec = hit_vec & ~before_vec;
        hit_any   = |hit_vec;
        match     = (r_ocnt != '0) && (r_stamp[0] == i_cmd.stamp) && hit_any;
    end

    // status decode
    always_comb begin
        n_res = ST_NONE;
        case (i_cmd.op)
            OP_PUT_STAMP:   n_res = oful ? ST_FULL : ST_INSERTED;
            OP_PUT_VERDICT: n_res = vful ? ST_FULL : ST_INSERTED;
            OP_POLL: begin
                if (match) begin
                    n_res = ST_PASS;
                    for (int k = 0; k < VERDICT_DEPTH; k++) begin
                        if (first_vec[k] && r_vent[k][ID_W]) begin
                            n_res = ST_BLOCK;
                        end
                    end
                end
            end
            default: n_res = ST_NONE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt  <= '0;
            r_vcnt  <= '0;
            r_res_v <= 1'b0;
        end else begin
            if (i_pop && r_res_v) begin
                r_res_v <= 1'b0;
            end
            if (o_take) begin
                r_res_v <= 1'b1;
                case (i_cmd.op)
                    OP_PUT_STAMP:   if (!oful) r_ocnt <= r_ocnt + 1'b1;
                    OP_PUT_VERDICT: if (!vful) r_vcnt <= r_vcnt + 1'b1;
                    OP_POLL: begin
                        if (match) begin
                            r_ocnt <= r_ocnt - 1'b1;
                            r_vcnt <= r_vcnt - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

    // store shifting: insert after equal stamps, remove head or hit
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            case (i_cmd.op)
                OP_PUT_STAMP: begin
                    if (!oful) begin
                        if (!le_vec[0]) begin
                            r_stamp[0] <= i_cmd.stamp;
                        end
                        for (int k = 1; k < ORDER_DEPTH; k++) begin
                            if (!le_vec[k]) begin
                                if (le_vec[k-1]) begin
                                    r_stamp[k] <= i_cmd.stamp;
                                end else begin
                                    r_stamp[k] <= r_stamp[k-1];
                                end
                            end
                        end
                    end
                end
                OP_PUT_VERDICT: begin
                    if (!vful) begin
                        for (int k = 0; k < VERDICT_DEPTH; k++) begin
                            if (VCW'(k) == r_vcnt) begin
                                r_vent[k] <= {i_cmd.block_bit, i_cmd.flow_id};
                            end
                        end
                    end
                end
                OP_POLL: begin
                    if (match) begin
                        for (int k = 0; k < ORDER_DEPTH - 1; k++) begin
                            r_stamp[k] <= r_stamp[k+1];
                        end
                        for (int k = 0; k < VERDICT_DEPTH - 1; k++) begin
                            if (before_vec[k] || first_vec[k]) begin
                                r_vent[k] <= r_vent[k+1];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/ordered_verdict_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_verdict_matcher
// pairs ordered packet timestamps with verdicts looked up by flow id
//
//   channel   handshake        payload
//   command   push / full      i_operation, i_stamp, i_flow_id, i_block_bit
//   result    empty / pop      o_status
//
// a transaction accepted at one edge is registered in the two-entry queue
// the engine takes it from the queue head and registers its status onto o_status
// the engine finishes one transaction per cycle through parallel compares, but
// a waiting result stalls it; the two-entry queue then fills and full rises
// reset clears the counts and queues; no clearing pass
// ----------------------------------------------------------------------------
module ordered_verdict_matcher import ovm_pkg::*; #(
    parameter int ORDER_DEPTH   = ORDER_DEPTH_DEF,
    parameter int VERDICT_DEPTH = VERDICT_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         i_operation,
    input  wire logic [STAMP_W-1:0] i_stamp,
    input  wire logic [ID_W-1:0]    i_flow_id,
    input  wire logic               i_block_bit,
    output logic                    empty,
    input  wire logic               pop,
    output logic [2:0]              o_status
);
    t_cmd in_cmd, q_cmd;
    logic q_valid, q_take;

    assign in_cmd = '{op: i_operation, stamp: i_stamp,
                      flow_id: i_flow_id, block_bit: i_block_bit};

    // front: command queue
    ovm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_cmd(in_cmd), .o_valid(q_valid), .o_cmd(q_cmd), .i_take(q_take)
    );

    // back: store engine
    ovm_back #(.ORDER_DEPTH(ORDER_DEPTH), .VERDICT_DEPTH(VERDICT_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(q_cmd),
        .o_take(q_take), .o_empty(empty), .o_status(o_status), .i_pop(pop)
    );
endmodule
`default_nettype wire

// ===== rtl/core/ovm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ovm_checker
// port-level checks on the ordered verdict matcher
// ----------------------------------------------------------------------------
module ovm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [2:0] o_status
);
    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown after reset");
    // status code in range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= 3'd4)) else $error("bad status");
    // waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status))) else $error("result lost");
    // the input queue only fills through an accepted transaction
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push)) else $error("full without a transaction");
endmodule

bind ordered_verdict_matcher ovm_checker u_ovm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
    .empty(empty), .pop(pop), .o_status(o_status)
);
`default_nettype wire
